// ===== sv/sparse_complex_matvec_csc_top_defines.svh =====
// Assertion macros for the sparse complex matvec block
`ifndef SPARSE_COMPLEX_MATVEC_CSC_TOP_DEFINES_SVH
`define SPARSE_COMPLEX_MATVEC_CSC_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scm: implication check failed");

// antecedent implies consequent in the next cycle
`define SCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scm: next-cycle check failed");

`endif

// ===== sv/scm_pkg.sv =====
package scm_pkg;

  localparam int MaxDim = 1024;
  localparam int MaxNz = 16384;
  localparam int DimW = $clog2(MaxDim);
  localparam int NzW = $clog2(MaxNz);
  localparam int CntW = DimW + 1;
  localparam int PtrW = NzW + 1;
  localparam int PosW = 14;
  localparam int CfgW = 32;
  localparam int CfgIdxW = 3;

  localparam logic [2:0] OP_WX = 3'd0;
  localparam logic [2:0] OP_WY = 3'd1;
  localparam logic [2:0] OP_WCOL = 3'd2;
  localparam logic [2:0] OP_WNZ = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;
  localparam logic [2:0] OP_RD = 3'd5;

  localparam logic [CfgIdxW-1:0] CFG_TRANS = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ARE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AIM = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BRE = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BIM = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ROWS = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_COLS = 3'd6;

  localparam logic RK_DONE = 1'b0;
  localparam logic RK_READ = 1'b1;

  localparam logic [1:0] YA_POS = 2'd0;
  localparam logic [1:0] YA_I = 2'd1;
  localparam logic [1:0] YA_ROW = 2'd2;
  localparam logic [1:0] YA_J = 2'd3;

  localparam logic [2:0] MS_BETA_Y = 3'd0;
  localparam logic [2:0] MS_ALPHA_X = 3'd1;
  localparam logic [2:0] MS_T_VAL = 3'd2;
  localparam logic [2:0] MS_VAL_X = 3'd3;
  localparam logic [2:0] MS_ALPHA_ACC = 3'd4;

  localparam logic signed [31:0] QOne = 32'sh0001_0000;

  typedef struct packed {
    logic signed [31:0] im;
    logic signed [31:0] re;
  } cplx_t;

  typedef struct packed {
    logic       y_re;
    logic [1:0] y_ra_sel;
    logic       y_we_scale;
    logic       y_we_acc;
    logic       acc_use_j;
    logic       x_re;
    logic       x_ra_row;
    logic       c_re;
    logic       c_ra_next;
    logic       nz_re;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       prod_en;
    logic       t_en;
    logic       acc_clr;
    logic       acc_en;
    logic       s_en;
    logic       span_en;
    logic       i_clr;
    logic       i_inc;
    logic       j_clr;
    logic       j_inc;
    logic       r_en;
    logic       out_load;
    logic       out_kind;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic beta_one;
    logic alpha_zero;
    logic transpose;
    logic nz_done;
    logic scale_last;
    logic col_last;
    logic x_zero;
    logic out_busy;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd2147483647;
    lo = -50'sd2147483648;
    if (v > hi) return 32'sh7fff_ffff;
    else if (v < lo) return 32'sh8000_0000;
    else return $signed(v[31:0]);
  endfunction

  function automatic cplx_t cadd(input cplx_t a, input cplx_t b);
    cplx_t r;
    r.re = sat32(50'(a.re) + 50'(b.re));
    r.im = sat32(50'(a.im) + 50'(b.im));
    return r;
  endfunction

endpackage

// ===== sv/scm_ram.sv =====
module scm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/scm_ctrl.sv =====
module scm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_accept_i,
  input  logic [2:0]    opcode_i,
  input  scm_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output scm_pkg::cmd_t cmd_o
);
  import scm_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDY = 5'd1;
  localparam logic [4:0] S_CINIT = 5'd2;
  localparam logic [4:0] S_SC_RD = 5'd3;
  localparam logic [4:0] S_SC_MUL = 5'd4;
  localparam logic [4:0] S_SC_CMB = 5'd5;
  localparam logic [4:0] S_SC_WR = 5'd6;
  localparam logic [4:0] S_COL0 = 5'd7;
  localparam logic [4:0] S_COL1 = 5'd8;
  localparam logic [4:0] S_COL2 = 5'd9;
  localparam logic [4:0] S_NX = 5'd10;
  localparam logic [4:0] S_NXC = 5'd11;
  localparam logic [4:0] S_NNZ = 5'd12;
  localparam logic [4:0] S_NNZ1 = 5'd13;
  localparam logic [4:0] S_NNZ2 = 5'd14;
  localparam logic [4:0] S_NNZ3 = 5'd15;
  localparam logic [4:0] S_TNZ = 5'd16;
  localparam logic [4:0] S_TNZ1 = 5'd17;
  localparam logic [4:0] S_TNZ2 = 5'd18;
  localparam logic [4:0] S_TNZ3 = 5'd19;
  localparam logic [4:0] S_TA = 5'd20;
  localparam logic [4:0] S_TA1 = 5'd21;
  localparam logic [4:0] S_TA2 = 5'd22;
  localparam logic [4:0] S_NEXTCOL = 5'd23;
  localparam logic [4:0] S_DONE = 5'd24;

  logic [4:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept_i && opcode_i == OP_RD) begin
          cmd_o.y_re = 1'b1;
          cmd_o.y_ra_sel = YA_POS;
          state_d = S_RDY;
        end else if (in_accept_i && opcode_i == OP_CMP) begin
          state_d = S_CINIT;
        end
      end
      S_RDY: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = RK_READ;
          state_d = S_IDLE;
        end
      end
      S_CINIT: begin
        if (sts_i.skip) begin
          state_d = S_DONE;
        end else if (!sts_i.beta_one) begin
          cmd_o.i_clr = 1'b1;
          state_d = S_SC_RD;
        end else begin
          cmd_o.j_clr = 1'b1;
          state_d = S_COL0;
        end
      end
      S_SC_RD: begin
        cmd_o.y_re = 1'b1;
        cmd_o.y_ra_sel = YA_I;
        state_d = S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MS_BETA_Y;
        state_d = S_SC_CMB;
      end
      S_SC_CMB: begin
        cmd_o.prod_en = 1'b1;
        state_d = S_SC_WR;
      end
      S_SC_WR: begin
        cmd_o.y_we_scale = 1'b1;
        if (!sts_i.scale_last) begin
          cmd_o.i_inc = 1'b1;
          state_d = S_SC_RD;
        end else if (sts_i.alpha_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.j_clr = 1'b1;
          state_d = S_COL0;
        end
      end
      S_COL0: begin
        cmd_o.c_re = 1'b1;
        state_d = S_COL1;
      end
      S_COL1: begin
        cmd_o.s_en = 1'b1;
        cmd_o.c_re = 1'b1;
        cmd_o.c_ra_next = 1'b1;
        state_d = S_COL2;
      end
      S_COL2: begin
        cmd_o.span_en = 1'b1;
        if (sts_i.transpose) begin
          cmd_o.acc_clr = 1'b1;
          state_d = S_TNZ;
        end else begin
          cmd_o.x_re = 1'b1;
          state_d = S_NX;
        end
      end
      S_NX: begin
        if (sts_i.x_zero) begin
          state_d = S_NEXTCOL;
        end else begin
          cmd_o.mul_en = 1'b1;
          cmd_o.mul_sel = MS_ALPHA_X;
          state_d = S_NXC;
        end
      end
      S_NXC: begin
        cmd_o.t_en = 1'b1;
        state_d = S_NNZ;
      end
      S_NNZ: begin
        if (sts_i.nz_done) begin
          state_d = S_NEXTCOL;
        end else begin
          cmd_o.nz_re = 1'b1;
          state_d = S_NNZ1;
        end
      end
      S_NNZ1: begin
        cmd_o.r_en = 1'b1;
        cmd_o.y_re = 1'b1;
        cmd_o.y_ra_sel = YA_ROW;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MS_T_VAL;
        state_d = S_NNZ2;
      end
      S_NNZ2: begin
        cmd_o.prod_en = 1'b1;
        state_d = S_NNZ3;
      end
      S_NNZ3: begin
        cmd_o.y_we_acc = 1'b1;
        cmd_o.i_inc = 1'b1;
        state_d = S_NNZ;
      end
      S_TNZ: begin
        if (sts_i.nz_done) begin
          state_d = S_TA;
        end else begin
          cmd_o.nz_re = 1'b1;
          state_d = S_TNZ1;
        end
      end
      S_TNZ1: begin
        cmd_o.x_re = 1'b1;
        cmd_o.x_ra_row = 1'b1;
        state_d = S_TNZ2;
      end
      S_TNZ2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MS_VAL_X;
        state_d = S_TNZ3;
      end
      S_TNZ3: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.i_inc = 1'b1;
        state_d = S_TNZ;
      end
      S_TA: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = MS_ALPHA_ACC;
        cmd_o.y_re = 1'b1;
        cmd_o.y_ra_sel = YA_J;
        state_d = S_TA1;
      end
      S_TA1: begin
        cmd_o.prod_en = 1'b1;
        state_d = S_TA2;
      end
      S_TA2: begin
        cmd_o.y_we_acc = 1'b1;
        cmd_o.acc_use_j = 1'b1;
        state_d = S_NEXTCOL;
      end
      S_NEXTCOL: begin
        if (sts_i.col_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d = S_COL0;
        end
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = RK_DONE;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/scm_dpath.sv =====
module scm_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [scm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [scm_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_accept_i,
  input  logic [2:0]                  opcode_i,
  input  logic [scm_pkg::PosW-1:0]    position_i,
  input  logic [scm_pkg::DimW-1:0]    row_number_i,
  input  logic [scm_pkg::PtrW-1:0]    pointer_value_i,
  input  logic signed [31:0]          data_real_i,
  input  logic signed [31:0]          data_imag_i,
  input  scm_pkg::cmd_t               cmd_i,
  output scm_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        result_kind_o,
  output logic [scm_pkg::DimW-1:0]    element_index_o,
  output logic signed [31:0]          result_real_o,
  output logic signed [31:0]          result_imag_o
);
  import scm_pkg::*;

  localparam logic [CntW-1:0] DimCnt = CntW'(MaxDim);
  localparam logic [PtrW-1:0] NzCnt = PtrW'(MaxNz);
  localparam logic [PosW:0] DimLim = (PosW + 1)'(MaxDim);
  localparam logic [PosW:0] NzLim = (PosW + 1)'(MaxNz);

  logic              trans_q;
  cplx_t             alpha_q, beta_q;
  logic [CntW-1:0]   rows_q, cols_q;
  logic [CntW-1:0]   nrow, ncol, leny;
  logic              alpha_zero, beta_one, beta_zero;

  logic [PtrW-1:0]   i_q, e_q, s_q;
  logic [CntW-1:0]   j_q;
  logic [DimW-1:0]   r_q;
  logic [PosW-1:0]   pos_q;
  cplx_t             t_q, acc_q, prod_q;
  logic signed [63:0] p_q [4];

  cplx_t             in_data;
  cplx_t             x_rd, y_rd, v_rd;
  logic [DimW-1:0]   row_rd;
  logic [PtrW-1:0]   col_rd;
  cplx_t             ma, mb, cmb;
  logic [PtrW-1:0]   span_e, span_s;
  logic [PosW:0]     pos_ext;

  logic              y_we, x_we, c_we, nz_we;
  logic [DimW-1:0]   y_wa, y_ra, x_ra;
  cplx_t             y_wd;
  logic [CntW-1:0]   c_ra;

  logic              ovalid_q, okind_q;
  logic [DimW-1:0]   oidx_q;
  cplx_t             odata_q;

  assign in_data.re = data_real_i;
  assign in_data.im = data_imag_i;
  assign pos_ext = {1'b0, position_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_q <= 1'b0;
      alpha_q.re <= QOne;
      alpha_q.im <= '0;
      beta_q.re <= QOne;
      beta_q.im <= '0;
      rows_q <= '0;
      cols_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRANS: trans_q <= cfg_data_i[0];
        CFG_ARE: alpha_q.re <= $signed(cfg_data_i);
        CFG_AIM: alpha_q.im <= $signed(cfg_data_i);
        CFG_BRE: beta_q.re <= $signed(cfg_data_i);
        CFG_BIM: beta_q.im <= $signed(cfg_data_i);
        CFG_ROWS: rows_q <= cfg_data_i[CntW-1:0];
        CFG_COLS: cols_q <= cfg_data_i[CntW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign nrow = (rows_q > DimCnt) ? DimCnt : rows_q;
  assign ncol = (cols_q > DimCnt) ? DimCnt : cols_q;
  assign leny = trans_q ? ncol : nrow;
  assign alpha_zero = (alpha_q == '0);
  assign beta_zero = (beta_q == '0);
  assign beta_one = (beta_q.re == QOne) && (beta_q.im == '0);

  assign sts_o.skip = (nrow == '0) || (ncol == '0) || (alpha_zero && beta_one);
  assign sts_o.beta_one = beta_one;
  assign sts_o.alpha_zero = alpha_zero;
  assign sts_o.transpose = trans_q;
  assign sts_o.nz_done = (i_q >= e_q);
  assign sts_o.scale_last = (i_q == (PtrW'(leny) - PtrW'(1)));
  assign sts_o.col_last = (j_q == (ncol - CntW'(1)));
  assign sts_o.x_zero = (x_rd == '0);
  assign sts_o.out_busy = ovalid_q && !out_ready_i;

  // memories
  assign x_we = in_accept_i && (opcode_i == OP_WX) && (pos_ext < DimLim);
  assign c_we = in_accept_i && (opcode_i == OP_WCOL) && (pos_ext <= DimLim);
  assign nz_we = in_accept_i && (opcode_i == OP_WNZ) && (pos_ext < NzLim);
  assign y_we = (in_accept_i && (opcode_i == OP_WY) && (pos_ext < DimLim))
              || cmd_i.y_we_scale || cmd_i.y_we_acc;

  assign x_ra = cmd_i.x_ra_row ? row_rd : j_q[DimW-1:0];
  assign c_ra = cmd_i.c_ra_next ? (j_q + CntW'(1)) : j_q;

  always_comb begin
    unique case (cmd_i.y_ra_sel)
      YA_POS: y_ra = position_i[DimW-1:0];
      YA_I: y_ra = i_q[DimW-1:0];
      YA_ROW: y_ra = row_rd;
      YA_J: y_ra = j_q[DimW-1:0];
      default: y_ra = '0;
    endcase
  end

  always_comb begin
    if (cmd_i.y_we_scale) begin
      y_wa = i_q[DimW-1:0];
      y_wd = beta_zero ? '0 : prod_q;
    end else if (cmd_i.y_we_acc) begin
      y_wa = cmd_i.acc_use_j ? j_q[DimW-1:0] : r_q;
      y_wd = cadd(y_rd, prod_q);
    end else begin
      y_wa = position_i[DimW-1:0];
      y_wd = in_data;
    end
  end

  scm_ram #(.WIDTH(64), .DEPTH(MaxDim)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (position_i[DimW-1:0]),
    .wdata_i (in_data),
    .re_i    (cmd_i.x_re),
    .raddr_i (x_ra),
    .rdata_o (x_rd)
  );

  scm_ram #(.WIDTH(64), .DEPTH(MaxDim)) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (y_wa),
    .wdata_i (y_wd),
    .re_i    (cmd_i.y_re),
    .raddr_i (y_ra),
    .rdata_o (y_rd)
  );

  scm_ram #(.WIDTH(PtrW), .DEPTH(MaxDim + 1)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (position_i[CntW-1:0]),
    .wdata_i (pointer_value_i),
    .re_i    (cmd_i.c_re),
    .raddr_i (c_ra),
    .rdata_o (col_rd)
  );

  scm_ram #(.WIDTH(DimW), .DEPTH(MaxNz)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (nz_we),
    .waddr_i (position_i[NzW-1:0]),
    .wdata_i (row_number_i),
    .re_i    (cmd_i.nz_re),
    .raddr_i (i_q[NzW-1:0]),
    .rdata_o (row_rd)
  );

  scm_ram #(.WIDTH(64), .DEPTH(MaxNz)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (nz_we),
    .waddr_i (position_i[NzW-1:0]),
    .wdata_i (in_data),
    .re_i    (cmd_i.nz_re),
    .raddr_i (i_q[NzW-1:0]),
    .rdata_o (v_rd)
  );

  // complex multiplier: four products, then floor, combine and saturate
  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_BETA_Y: begin
        ma = beta_q;
        mb = y_rd;
      end
      MS_ALPHA_X: begin
        ma = alpha_q;
        mb = x_rd;
      end
      MS_T_VAL: begin
        ma = t_q;
        mb = v_rd;
      end
      MS_VAL_X: begin
        ma = v_rd;
        mb = x_rd;
      end
      MS_ALPHA_ACC: begin
        ma = alpha_q;
        mb = acc_q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_q[0] <= 64'(ma.re) * 64'(mb.re);
      p_q[1] <= 64'(ma.im) * 64'(mb.im);
      p_q[2] <= 64'(ma.re) * 64'(mb.im);
      p_q[3] <= 64'(ma.im) * 64'(mb.re);
    end
  end

  always_comb begin
    cmb.re = sat32(50'(p_q[0] >>> 16) - 50'(p_q[1] >>> 16));
    cmb.im = sat32(50'(p_q[2] >>> 16) + 50'(p_q[3] >>> 16));
  end

  assign span_e = (col_rd > NzCnt) ? NzCnt : col_rd;
  assign span_s = (s_q > span_e) ? span_e : s_q;

  always_ff @(posedge clk_i) begin
    if (in_accept_i) pos_q <= position_i;
    if (cmd_i.prod_en) prod_q <= cmb;
    if (cmd_i.t_en) t_q <= cmb;
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.acc_en) acc_q <= cadd(acc_q, cmb);
    if (cmd_i.s_en) s_q <= col_rd;
    if (cmd_i.span_en) e_q <= span_e;
    if (cmd_i.r_en || cmd_i.x_ra_row) r_q <= row_rd;
    if (cmd_i.span_en) i_q <= span_s;
    else if (cmd_i.i_clr) i_q <= '0;
    else if (cmd_i.i_inc) i_q <= i_q + PtrW'(1);
    if (cmd_i.j_clr) j_q <= '0;
    else if (cmd_i.j_inc) j_q <= j_q + CntW'(1);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      okind_q <= cmd_i.out_kind;
      if (cmd_i.out_kind == RK_READ) begin
        oidx_q <= pos_q[DimW-1:0];
        odata_q <= ({1'b0, pos_q} < DimLim) ? y_rd : '0;
      end else begin
        oidx_q <= '0;
        odata_q <= '0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign result_kind_o = okind_q;
  assign element_index_o = oidx_q;
  assign result_real_o = odata_q.re;
  assign result_imag_o = odata_q.im;

endmodule

// ===== sv/sparse_complex_matvec_csc_top.sv =====
// Load items (x, y, column pointer, nonzero) are accepted one per cycle while idle.
// Read y: the y word is read, then registered as the result once the output is free;
// no new item is accepted before that. Compute: scales y by beta unless beta is one,
// then, unless alpha is zero, walks each column's nonzeros (normal mode skips zero x).
// Reset clears configuration to defaults and control state; vector and matrix
// memories hold no reset value and must be loaded before use.
`include "sparse_complex_matvec_csc_top_defines.svh"

module sparse_complex_matvec_csc_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [scm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [scm_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // position, row_number, pointer_value, data_real, data_imag, zero pad
  input  logic [103:0]                s_axis_tdata,
  // opcode
  input  logic [2:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // element_index, result_real, result_imag, zero pad
  output logic [79:0]                 m_axis_tdata,
  // result_kind
  output logic                        m_axis_tuser
);
  import scm_pkg::*;

  logic            in_accept;
  cmd_t            cmd;
  sts_t            sts;
  logic [DimW-1:0] el_idx;
  logic signed [31:0] res_re, res_im;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  scm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .opcode_i    (s_axis_tuser),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  scm_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_accept_i     (in_accept),
    .opcode_i        (s_axis_tuser),
    .position_i      (s_axis_tdata[13:0]),
    .row_number_i    (s_axis_tdata[23:14]),
    .pointer_value_i (s_axis_tdata[38:24]),
    .data_real_i     ($signed(s_axis_tdata[70:39])),
    .data_imag_i     ($signed(s_axis_tdata[102:71])),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .result_kind_o   (m_axis_tuser),
    .element_index_o (el_idx),
    .result_real_o   (res_re),
    .result_imag_o   (res_im)
  );

  assign m_axis_tdata = {6'b0, res_im, res_re, el_idx};

  `SCM_ASSERT_IMP(a_load_free, cmd.out_load, !sts.out_busy)
  `SCM_ASSERT_IMP(a_no_calc_write_idle, cmd.y_we_scale || cmd.y_we_acc, !s_axis_tready)
  `SCM_ASSERT_IMP(a_done_zero, m_axis_tvalid && (m_axis_tuser == RK_DONE), m_axis_tdata == '0)
  `SCM_ASSERT_NXT(a_load_shows, cmd.out_load, m_axis_tvalid)

endmodule
